[hdl/stream_boundary_splitter_macros.svh]
// assertion macros for the stream boundary splitter
// expects signals named clock and reset in the including scope
`ifndef STREAM_BOUNDARY_SPLITTER_MACROS_SVH
`define STREAM_BOUNDARY_SPLITTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sbs_pkg.sv]
// shared types and constants of the stream boundary splitter
// no dependencies
package sbs_pkg;

   localparam int MAX_PATTERN = 128;
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;
   localparam int BYTE_W      = 8;
   localparam int PIDX_W      = 7;
   localparam int HELD_W      = 8;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2,
      KIND_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RES_DATA     = 2'd0,
      RES_BOUNDARY = 2'd1,
      RES_END      = 2'd2
   } res_kind_type;

   typedef struct packed {
      res_kind_type             result_kind;
      logic [BYTE_W-1:0]        data_byte;
      logic [HELD_W-1:0]        held_count;
   } result_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic                     data_go;
      logic                     load_go;
      logic                     shift;
      logic [BYTE_W-1:0]        value;
      logic [CMP_W-1:0]         load_index;
      logic [CMP_W-1:0]         fill;
      logic [CMP_W-1:0]         length;
   } cell_ctrl_type;

endpackage

[hdl/sbs_intf.sv]
// handshake channels of the stream boundary splitter: request, response, register write
// depends on sbs_pkg
interface sbs_req_if;
   logic                              valid;
   logic                              ready;
   sbs_pkg::req_kind_type             kind;
   logic [sbs_pkg::BYTE_W-1:0]        value;
   logic [sbs_pkg::PIDX_W-1:0]        pattern_index;

   modport source (output valid, output kind, output value, output pattern_index,
                   input ready);
   modport sink   (input valid, input kind, input value, input pattern_index,
                   output ready);
endinterface

interface sbs_rsp_if;
   logic                              valid;
   logic                              ready;
   sbs_pkg::res_kind_type             result_kind;
   logic [sbs_pkg::BYTE_W-1:0]        data_byte;
   logic [sbs_pkg::HELD_W-1:0]        held_count;

   modport source (output valid, output result_kind, output data_byte, output held_count,
                   input ready);
   modport sink   (input valid, input result_kind, input data_byte, input held_count,
                   output ready);
endinterface

interface sbs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sbs_pkg::BYTE_W-1:0]        data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/sbs_cell.sv]
// one window position: holds a delimiter byte and a window byte
// depends on sbs_pkg
module sbs_cell (
   input  logic                          clock,
   input  logic [sbs_pkg::CMP_W-1:0]     cell_index,
   input  sbs_pkg::cell_ctrl_type        ctrl,
   input  logic [sbs_pkg::BYTE_W-1:0]    nbr_byte,
   output logic [sbs_pkg::BYTE_W-1:0]    eff_byte,
   output logic                          eq
);

   logic [sbs_pkg::BYTE_W-1:0] pat_ff;
   logic [sbs_pkg::BYTE_W-1:0] win_ff;
   logic [sbs_pkg::BYTE_W-1:0] win_in;
   logic                       in_use;

   // the incoming byte lands in the cell at the fill position
   assign eff_byte = (ctrl.data_go && (ctrl.fill == cell_index)) ? ctrl.value : win_ff;
   assign in_use   = cell_index < ctrl.length;
   assign eq       = !in_use || (eff_byte == pat_ff);
   assign win_in   = ctrl.shift ? nbr_byte : eff_byte;

   always_ff @(posedge clock) begin
      if (ctrl.data_go) begin
         win_ff <= win_in;
      end
      if (ctrl.load_go && (ctrl.load_index == cell_index)) begin
         pat_ff <= ctrl.value;
      end
   end

endmodule

[hdl/sbs_result_buf.sv]
// two-entry output stage: output register plus skid register
// depends on sbs_pkg and sbs_intf
module sbs_result_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sbs_pkg::result_type   push_data,
   output logic                  can_take,
   sbs_rsp_if.source             rsp
);

   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   sbs_pkg::result_type  out_ff;
   sbs_pkg::result_type  skid_ff;

   assign can_take        = !skid_valid_ff;
   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = out_ff.result_kind;
   assign rsp.data_byte   = out_ff.data_byte;
   assign rsp.held_count  = out_ff.held_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp.ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp.ready) begin
         out_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule

[hdl/stream_boundary_splitter.sv]
// top level of the stream boundary splitter: row of window cells, fill and length control
// depends on sbs_pkg, sbs_intf, sbs_cell, sbs_result_buf and the macros header
//
// Searches a byte stream for a delimiter of pattern_length bytes (1 to MAX_PATTERN). Delimiter
// bytes are loaded by index with load items; data items enter a window that lives in a row of
// cells, one cell per delimiter position. Once the window is full, each data item either reports
// a boundary (window equals the delimiter, the window empties) or passes the oldest window byte
// out as data. An end item reports the number of bytes still held; a clear item or a write of
// pattern_length empties the window. The block takes one item every cycle while the output
// stage has room: all cells compare their bytes in the same cycle and the shift of the window
// happens at the same clock edge, so one item's result is known before the next arrives. A
// result is registered in the output stage before it shows on the response channel. While the
// response side stalls, a two-entry output stage holds one more result; the request side stops
// only once both entries are full, and items without a result keep flowing until then.
// Delimiter positions never loaded read as unknown.
`include "stream_boundary_splitter_macros.svh"

module stream_boundary_splitter (
   input  logic        clock,
   input  logic        reset,
   sbs_req_if.sink     req_bus,
   sbs_rsp_if.source   rsp_bus,
   sbs_csr_if.sink     csr_bus
);

   localparam int MAXP  = sbs_pkg::MAX_PATTERN;
   localparam int CNT_W = sbs_pkg::CNT_W;
   localparam int CMP_W = sbs_pkg::CMP_W;

   // window state
   logic [CNT_W-1:0]            fill_ff;
   logic [CNT_W-1:0]            fill_in;
   logic [CNT_W-1:0]            length_ff;
   logic [CNT_W-1:0]            length_in;
   logic [CMP_W-1:0]            csr_len;

   // handshake and per-item decode
   logic                        accept;
   logic                        csr_write;
   logic                        data_go;
   logic                        full;
   logic                        all_eq;
   logic                        push;
   logic                        can_take;
   sbs_pkg::result_type         push_data;
   sbs_pkg::cell_ctrl_type      ctrl;

   // cell row
   logic [sbs_pkg::BYTE_W-1:0]  eff_bytes [MAXP];
   logic [sbs_pkg::BYTE_W-1:0]  nbr_bytes [MAXP];
   logic [MAXP-1:0]             eq_vec;

   assign accept      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = can_take;
   assign csr_bus.ready = 1'b1;
   assign csr_write   = csr_bus.valid && csr_bus.ready;
   assign data_go     = accept && (req_bus.kind == sbs_pkg::KIND_DATA);

   // fill never exceeds length - 1 between items, so the new byte fills the window
   // exactly when fill + 1 reaches the length
   assign full   = ({1'b0, fill_ff} + (CNT_W+1)'(1)) >= {1'b0, length_ff};
   assign all_eq = &eq_vec;

   // broadcast to the cells
   assign ctrl.data_go    = data_go;
   assign ctrl.load_go    = accept && (req_bus.kind == sbs_pkg::KIND_LOAD);
   assign ctrl.shift      = data_go && full && !all_eq;
   assign ctrl.value      = req_bus.value;
   assign ctrl.load_index = CMP_W'(req_bus.pattern_index);
   assign ctrl.fill       = CMP_W'(fill_ff);
   assign ctrl.length     = CMP_W'(length_ff);

   genvar g;
   generate
      for (g = 0; g < MAXP; g++) begin : g_cell
         // each cell takes its upper neighbor's byte when the window shifts
         if (g == MAXP - 1) begin : g_last
            assign nbr_bytes[g] = '0;
         end else begin : g_mid
            assign nbr_bytes[g] = eff_bytes[g+1];
         end

         sbs_cell u_cell (
            .clock      (clock),
            .cell_index (CMP_W'(g)),
            .ctrl       (ctrl),
            .nbr_byte   (nbr_bytes[g]),
            .eff_byte   (eff_bytes[g]),
            .eq         (eq_vec[g])
         );
      end
   endgenerate

   // result of the accepted item, if it has one
   always_comb begin
      push                  = 1'b0;
      push_data.result_kind = sbs_pkg::RES_DATA;
      push_data.data_byte   = '0;
      push_data.held_count  = '0;
      case (req_bus.kind)
         sbs_pkg::KIND_DATA: begin
            push = data_go && full;
            if (all_eq) begin
               push_data.result_kind = sbs_pkg::RES_BOUNDARY;
            end else begin
               // oldest byte leaves from the bottom cell
               push_data.data_byte = eff_bytes[0];
            end
         end
         sbs_pkg::KIND_END: begin
            push                  = accept;
            push_data.result_kind = sbs_pkg::RES_END;
            push_data.held_count  = sbs_pkg::HELD_W'(fill_ff);
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // register write clamps the length into 1..MAX_PATTERN
   always_comb begin
      csr_len = CMP_W'(csr_bus.data);
      if (csr_len == '0) begin
         length_in = CNT_W'(1);
      end else if (csr_len > CMP_W'(MAXP)) begin
         length_in = CNT_W'(MAXP);
      end else begin
         length_in = CNT_W'(csr_len);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         case (req_bus.kind)
            sbs_pkg::KIND_DATA: begin
               if (!full) begin
                  fill_in = fill_ff + CNT_W'(1);
               end else if (all_eq) begin
                  fill_in = '0;
               end else begin
                  fill_in = fill_ff;
               end
            end
            sbs_pkg::KIND_CLEAR: begin
               fill_in = '0;
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
      if (csr_write) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         length_ff <= CNT_W'(1);
      end else begin
         fill_ff <= fill_in;
         if (csr_write) begin
            length_ff <= length_in;
         end
      end
   end

   sbs_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .can_take  (can_take),
      .rsp       (rsp_bus)
   );

   // window never holds a full delimiter between items
   `SBS_ASSERT_IMPLY(a_fill_below_length, 1'b1, fill_ff < length_ff, "window fill reached length")
   // a stalled request side means a result is waiting at the output
   `SBS_ASSERT_IMPLY(a_stall_has_result, !req_bus.ready, rsp_bus.valid, "stall without result")
   // after an accepted end item the output holds a valid result
   `SBS_ASSERT_NEXT(a_end_reported, accept && (req_bus.kind == sbs_pkg::KIND_END),
      rsp_bus.valid, "end item not reported")

endmodule
